// ----- rtl/patan_pkg.sv -----
// package for the polynomial atan2 pipeline
// holds widths, the Q1.15 coefficient table and the pi constant; no dependencies
package patan_pkg;
	localparam int IN_WIDTH_DEF = 16;
	localparam int ANGLE_FRAC_DEF = 13;
	localparam int NUM_COEF = 6;
	localparam int TW = 17;
	localparam logic [62:0] PI_Q61 = 63'd7244019458077122842;

	typedef logic signed [TW:0] coef_t;

	function automatic coef_t poly_coef(input logic [2:0] k);
		coef_t c;
		case (k)
			3'd0: c = -18'sd293;
			3'd1: c = 18'sd1484;
			3'd2: c = -18'sd3585;
			3'd3: c = 18'sd6247;
			3'd4: c = -18'sd10884;
			3'd5: c = 18'sd32767;
			default: c = '0;
		endcase
		return c;
	endfunction

	// quadrant info that travels with an item
	typedef struct packed {
		logic valid;
		logic zero;
		logic xmajor;
		logic xneg;
		logic yneg;
	} quad_t;
endpackage

// ----- rtl/patan_div.sv -----
// restoring divider for the ratio: small*2^15 + big/2, divided by big, one quotient bit a stage
// depends on patan_pkg
module patan_div #(
	parameter int IN_WIDTH = patan_pkg::IN_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  logic [IN_WIDTH-1:0] mag_lo,
	input  logic [IN_WIDTH-1:0] big,
	input  patan_pkg::quad_t quad_in,
	output logic out_valid,
	output logic [15:0] ratio,
	output patan_pkg::quad_t quad_out
);
	import patan_pkg::*;
	localparam int NW = IN_WIDTH + 15;
	localparam int QB = 16;
	localparam int RW = IN_WIDTH + 1;

	// stage k: remainder, remaining dividend bits, quotient so far
	logic [RW-1:0] rem_s [QB+1];
	logic [NW-1:0] num_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	logic [IN_WIDTH-1:0] den_s [QB+1];
	quad_t qd_s [QB+1];

	logic [NW-1:0] num0;
	// ratio < 2^16, so the top NW-16 bits of the numerator form a remainder below big
	assign num0 = {mag_lo, 15'd0} + NW'(big >> 1);

	always_comb begin
		rem_s[0] = RW'(num0 >> QB);
		num_s[0] = num0 << (NW - QB);
		quo_s[0] = '0;
		den_s[0] = big;
		qd_s[0] = quad_in;
		qd_s[0].valid = in_valid;
	end

	for (genvar k = 0; k < QB; k++) begin : g_st
		logic [RW-1:0] sh;
		logic [RW:0] diff;
		logic [RW-1:0] rem_q;
		logic [NW-1:0] num_q;
		logic [QB-1:0] quo_q;
		logic [IN_WIDTH-1:0] den_q;
		quad_t qd_q;
		always_comb begin
			sh = {rem_s[k][RW-2:0], num_s[k][NW-1]};
			diff = {1'b0, sh} - {2'b0, den_s[k]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				qd_q <= '0;
			end else if (adv) begin
				qd_q <= qd_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q <= diff[RW] ? sh : diff[RW-1:0];
				num_q <= num_s[k] << 1;
				quo_q <= {quo_s[k][QB-2:0], ~diff[RW]};
				den_q <= den_s[k];
			end
		end
		assign rem_s[k+1] = rem_q;
		assign num_s[k+1] = num_q;
		assign quo_s[k+1] = quo_q;
		assign den_s[k+1] = den_q;
		assign qd_s[k+1] = qd_q;
	end

	assign out_valid = qd_s[QB].valid;
	assign ratio = quo_s[QB];
	assign quad_out = qd_s[QB];
endmodule

// ----- rtl/patan_poly.sv -----
// Horner evaluation of t*P(t*t) with a register after every product, then quadrant fix
// depends on patan_pkg
module patan_poly #(
	parameter int ANGLE_FRAC_BITS = patan_pkg::ANGLE_FRAC_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic [15:0] ratio,
	input  patan_pkg::quad_t quad_in,
	output logic out_valid,
	output logic signed [ANGLE_FRAC_BITS+2:0] angle
);
	import patan_pkg::*;
	localparam int AW = ANGLE_FRAC_BITS + 3;
	localparam int PSH = 30 - ANGLE_FRAC_BITS;
	localparam int SH0 = 61 - ANGLE_FRAC_BITS;
	localparam int SH1 = 62 - ANGLE_FRAC_BITS;
	localparam logic [62:0] PI0 = (PI_Q61 + (63'd1 << (SH0 - 1))) >> SH0;
	localparam logic [62:0] PI1 = (PI_Q61 + (63'd1 << (SH1 - 1))) >> SH1;
	localparam int NH = NUM_COEF - 1;

	// round-to-nearest, ties up, of a signed product by 2^15
	function automatic logic signed [TW:0] rnd15(input logic signed [2*TW+1:0] p);
		logic signed [2*TW+1:0] s;
		s = (p + (36'sd1 <<< 14)) >>> 15;
		return s[TW:0];
	endfunction

	// stage 1: square of the ratio
	logic signed [TW:0] t_s1, t2_s1;
	quad_t qd_s1;
	logic signed [2*TW+1:0] sq;
	assign sq = $signed({2'b0, ratio}) * $signed({2'b0, ratio});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qd_s1 <= '0;
		end else if (adv) begin
			qd_s1 <= quad_in;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= $signed({2'b0, ratio});
			t2_s1 <= rnd15(sq);
		end
	end

	// Horner steps, one multiply each
	logic signed [TW:0] u_h [NH+1];
	logic signed [TW:0] t_h [NH+1];
	logic signed [TW:0] t2_h [NH+1];
	quad_t qd_h [NH+1];
	assign u_h[0] = poly_coef(3'd0);
	assign t_h[0] = t_s1;
	assign t2_h[0] = t2_s1;
	assign qd_h[0] = qd_s1;

	for (genvar k = 0; k < NH; k++) begin : g_h
		logic signed [2*TW+1:0] p;
		logic signed [TW:0] u_q, t_q, t2_q;
		quad_t qd_q;
		assign p = u_h[k] * t2_h[k];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				qd_q <= '0;
			end else if (adv) begin
				qd_q <= qd_h[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				u_q <= poly_coef(3'(k + 1)) + rnd15(p);
				t_q <= t_h[k];
				t2_q <= t2_h[k];
			end
		end
		assign u_h[k+1] = u_q;
		assign t_h[k+1] = t_q;
		assign t2_h[k+1] = t2_q;
		assign qd_h[k+1] = qd_q;
	end

	// final product u*t, rounded to the angle scale
	logic signed [2*TW+1:0] pf, pr;
	logic signed [AW-1:0] r_s2;
	quad_t qd_s2;
	assign pf = u_h[NH] * t_h[NH];
	assign pr = (pf + (36'sd1 <<< (PSH - 1))) >>> PSH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qd_s2 <= '0;
		end else if (adv) begin
			qd_s2 <= qd_h[NH];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			r_s2 <= pr[AW-1:0];
		end
	end

	// quadrant fix
	logic signed [AW-1:0] r_sg, a_nx;
	logic signed [AW-1:0] pi0, pi1;
	assign pi0 = AW'(PI0);
	assign pi1 = AW'(PI1);
	always_comb begin
		r_sg = (qd_s2.xneg != qd_s2.yneg) ? -r_s2 : r_s2;
		if (qd_s2.zero) begin
			a_nx = '0;
		end else if (qd_s2.xmajor) begin
			if (qd_s2.xneg) begin
				a_nx = r_sg + (qd_s2.yneg ? -pi0 : pi0);
			end else begin
				a_nx = r_sg;
			end
		end else begin
			a_nx = -r_sg + (qd_s2.yneg ? -pi1 : pi1);
		end
	end

	logic v_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= qd_s2.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			angle <= a_nx;
		end
	end
	assign out_valid = v_s3;
endmodule

// ----- rtl/polynomial_atan2_top.sv -----
// four-quadrant atan2 top level: front end, ratio divider, polynomial and quadrant stages
// depends on patan_pkg, patan_div, patan_poly
//
// usage:
//   input channel vec_y/vec_x with in_valid/in_stall; a transfer happens on a rising
//   edge with in_valid high and in_stall low
//   output channel angle with out_valid/out_stall, same transfer rule
//   angle is radians in two's complement with ANGLE_FRAC_BITS fraction bits
// pipeline: 1 magnitude stage, 16 divider stages, 1 squaring stage, 5 horner stages,
//   1 final product stage, 1 quadrant stage; the divider's one-quotient-bit-per-stage
//   chain makes up most of them
// throughput: one transfer per cycle while no result is held under out_stall; every stage
//   holds one item and the whole pipe moves as one
// stall: while out_stall is high with a result waiting, the pipe freezes and
//   in_stall rises; nothing is lost or repeated; empty slots let the pipe fill
// reset: arst_n low clears every valid bit; the pipe comes out empty
// both inputs zero give angle 0
module polynomial_atan2_top #(
	parameter int IN_WIDTH = patan_pkg::IN_WIDTH_DEF,
	parameter int ANGLE_FRAC_BITS = patan_pkg::ANGLE_FRAC_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [IN_WIDTH-1:0] vec_y,
	input  logic signed [IN_WIDTH-1:0] vec_x,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [ANGLE_FRAC_BITS+2:0] angle
);
	import patan_pkg::*;

	// the pipe advances unless a finished result is held by the receiver
	logic adv;
	logic pipe_valid;
	assign adv = !(pipe_valid && out_stall);
	assign in_stall = !adv;

	// front end: magnitudes and quadrant bits, magnitudes one bit wider for the most negative input
	logic [IN_WIDTH:0] ay, ax;
	assign ay = vec_y[IN_WIDTH-1] ? -{vec_y[IN_WIDTH-1], vec_y} : {1'b0, vec_y};
	assign ax = vec_x[IN_WIDTH-1] ? -{vec_x[IN_WIDTH-1], vec_x} : {1'b0, vec_x};

	logic [IN_WIDTH:0] small_s1, big_s1;
	quad_t qd_s1, qd_d;
	logic xm;
	assign xm = ax > ay;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qd_s1 <= '0;
		end else if (adv) begin
			qd_s1.valid <= in_valid;
			qd_s1.zero <= (ay == '0 && ax == '0);
			qd_s1.xmajor <= xm;
			qd_s1.xneg <= vec_x[IN_WIDTH-1];
			qd_s1.yneg <= vec_y[IN_WIDTH-1];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			small_s1 <= xm ? ay : ax;
			// zero pair divides by one to keep the divider clean; result is forced later
			big_s1 <= (ay == '0 && ax == '0) ? (IN_WIDTH+1)'(1) : (xm ? ax : ay);
		end
	end

	logic dv;
	logic [15:0] ratio;
	quad_t qd_r;
	patan_div #(.IN_WIDTH(IN_WIDTH + 1)) u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(qd_s1.valid),
		.mag_lo(small_s1), .big(big_s1), .quad_in(qd_s1),
		.out_valid(dv), .ratio(ratio), .quad_out(qd_d)
	);
	always_comb begin
		qd_r = qd_d;
		qd_r.valid = dv;
	end

	patan_poly #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_poly (
		.clk(clk), .arst_n(arst_n), .adv(adv), .ratio(ratio), .quad_in(qd_r),
		.out_valid(pipe_valid), .angle(angle)
	);
	assign out_valid = pipe_valid;

`ifndef ASSERT_OFF
	// a held result must not change while the receiver stalls
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(angle))
		else $error("result changed under stall");
	// input is stalled only when a result is held
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("spurious input stall");
	// angle stays within -pi..pi
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (angle <= $signed((ANGLE_FRAC_BITS+3)'(
			(PI_Q61 + (63'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS))))
		&& (angle >= -$signed((ANGLE_FRAC_BITS+3)'(
			(PI_Q61 + (63'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS)))))
		else $error("angle out of range");
`endif
endmodule
